// ===== sv/itc_pkg.sv =====
// Package for the interval table: status codes, modes, count limit, sequencer states and cell operations.
// No dependencies.
package itc_pkg;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_DUP  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_INSERT,
      ST_MERGE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_MERGE
   } op_type;

endpackage

// ===== sv/interval_table_coalescing.sv =====
// Sorted interval table built as a row of cells; each cell compares in parallel.
// Insert shifts the row by one cell; each merge step folds one upper neighbor into the entry.
// Depends on itc_pkg and itc_cell.
//
// One item is in work at a time. A query, a duplicate add and an add to a full table
// pass from the search state to the done state, which raises the result, and the next
// item is accepted once the sequencer is back in idle. An add that is inserted passes
// through a search step, an insert step that shifts the row, a step to the entry below
// if it touches the new one, one merge step for each upper neighbor folded in (two at
// most), a step that copies the merged entry into the result registers and the done
// state that raises the result valid; the next item again waits for idle.
// A result that waits holds off the next item until it is taken.
module interval_table_coalescing import itc_pkg::*; #(
   parameter int TABLE_DEPTH = 64,
   parameter int TIME_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [31:0] req_start_time,
   input  logic [31:0] req_span_length,
   input  logic [31:0] req_event_count,
   input  logic [31:0] req_probe_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_covered,
   output logic [31:0] rsp_hit_start,
   output logic [32:0] rsp_hit_length,
   output logic [31:0] rsp_hit_count
);
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   state_type state_ff, state_in;
   logic [CW-1:0] used_ff, used_in;
   logic mode_ff;
   logic [TIME_BITS-1:0] key_ff;
   logic [TIME_BITS:0] len_ff;
   logic [31:0] cnt_ff;
   logic [IW-1:0] pos_ff, pos_in;
   logic rv_ff, rv_in;
   logic [1:0] rs_ff, rs_in;
   logic rc_ff, rc_in;
   logic [TIME_BITS-1:0] rst_ff, rst_in;
   logic [TIME_BITS:0] rl_ff, rl_in;
   logic [31:0] rn_ff, rn_in;
   op_type op;

   logic [TIME_BITS-1:0] c_start [TABLE_DEPTH];
   logic [TIME_BITS:0]   c_len [TABLE_DEPTH];
   logic [31:0]          c_cnt [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] lt, le, eq, tch, valid;

   logic [CW-1:0] n_lt, n_le;
   logic [IW-1:0] hit_idx, lo_idx;
   logic dup, found;
   logic [TIME_BITS:0] diff;

   genvar g;
   generate
      for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
         logic [IW-1:0] gi;
         assign gi = IW'(g);
         assign valid[g] = CW'(g) < used_ff;
         itc_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .clock(clock), .op(op), .key(key_ff),
            .ins_here(gi == pos_ff),
            .merge_here(gi == pos_ff),
            .take_next(gi > pos_ff),
            .take_prev(gi > pos_ff),
            .new_start(key_ff), .new_length(len_ff), .new_count(cnt_ff),
            .prev_start(c_start[(g == 0) ? 0 : g-1]),
            .prev_length(c_len[(g == 0) ? 0 : g-1]),
            .prev_count(c_cnt[(g == 0) ? 0 : g-1]),
            .next_start(c_start[(g == TABLE_DEPTH-1) ? g : g+1]),
            .next_length(c_len[(g == TABLE_DEPTH-1) ? g : g+1]),
            .next_count(c_cnt[(g == TABLE_DEPTH-1) ? g : g+1]),
            .start(c_start[g]), .length(c_len[g]), .count(c_cnt[g]),
            .lt_key(lt[g]), .le_key(le[g]), .eq_key(eq[g]), .touch(tch[g])
         );
      end
   endgenerate

   // Entries are sorted, so the masked compare bits form a thermometer code and its
   // last set bit gives the number of entries below the key.
   always_comb begin
      n_lt = '0;
      n_le = '0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         if (lt[k] && valid[k]) n_lt = CW'(k + 1);
         if (le[k] && valid[k]) n_le = CW'(k + 1);
      end
   end

   assign hit_idx = IW'(n_le - CW'(1));
   assign found   = n_le != '0;
   assign dup     = (n_lt < used_ff) && eq[n_lt[IW-1:0]];
   assign diff    = {1'b0, key_ff} - {1'b0, c_start[hit_idx]};
   assign lo_idx  = (pos_ff != '0 && tch[pos_ff - IW'(1)]) ? pos_ff - IW'(1) : pos_ff;

   assign req_ready = (state_ff == ST_IDLE) && (!rv_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      used_in  = used_ff;
      pos_in   = pos_ff;
      rv_in    = rv_ff && !rsp_ready;
      rs_in    = rs_ff;
      rc_in    = rc_ff;
      rst_in   = rst_ff;
      rl_in    = rl_ff;
      rn_in    = rn_ff;
      op       = OP_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) state_in = ST_FIND;
         end
         ST_FIND: begin
            rs_in  = STATUS_DONE;
            rc_in  = 1'b0;
            rst_in = '0;
            rl_in  = '0;
            rn_in  = '0;
            pos_in = n_lt[IW-1:0];
            state_in = ST_DONE;
            if (mode_ff == MODE_QUERY) begin
               if (found && diff < c_len[hit_idx]) begin
                  rc_in  = 1'b1;
                  rst_in = c_start[hit_idx];
                  rl_in  = c_len[hit_idx];
                  rn_in  = c_cnt[hit_idx];
               end
            end else if (dup) begin
               rs_in  = STATUS_DUP;
               rst_in = c_start[n_lt[IW-1:0]];
               rl_in  = c_len[n_lt[IW-1:0]];
               rn_in  = c_cnt[n_lt[IW-1:0]];
            end else if (used_ff == CW'(TABLE_DEPTH)) begin
               rs_in = STATUS_FULL;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            op = OP_INSERT;
            used_in = used_ff + CW'(1);
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (lo_idx != pos_ff) begin
               pos_in = lo_idx;
            end else if (CW'(pos_ff) + CW'(1) < used_ff && tch[pos_ff]) begin
               op = OP_MERGE;
               used_in = used_ff - CW'(1);
            end else begin
               rst_in = c_start[pos_ff];
               rl_in  = c_len[pos_ff];
               rn_in  = c_cnt[pos_ff];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff <= req_mode;
         key_ff  <= (req_mode == MODE_QUERY) ? req_probe_time[TIME_BITS-1:0]
                                             : req_start_time[TIME_BITS-1:0];
         len_ff  <= {1'b0, req_span_length[TIME_BITS-1:0]};
         cnt_ff  <= req_event_count;
      end
      pos_ff <= pos_in;
      rs_ff  <= rs_in;
      rc_ff  <= rc_in;
      rst_ff <= rst_in;
      rl_ff  <= rl_in;
      rn_ff  <= rn_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = rs_ff;
   assign rsp_covered    = rc_ff;
   assign rsp_hit_start  = 32'(rst_ff);
   assign rsp_hit_length = 33'(rl_ff);
   assign rsp_hit_count  = rn_ff;
endmodule

// ===== sv/itc_cell.sv =====
// One table cell: holds a single interval and takes its neighbor's value on shifts.
// Depends on itc_pkg.
module itc_cell import itc_pkg::*; #(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  op_type               op,
   input  logic [TIME_BITS-1:0] key,
   input  logic                 ins_here,
   input  logic                 merge_here,
   input  logic                 take_next,
   input  logic                 take_prev,
   input  logic [TIME_BITS-1:0] new_start,
   input  logic [TIME_BITS:0]   new_length,
   input  logic [31:0]          new_count,
   input  logic [TIME_BITS-1:0] prev_start,
   input  logic [TIME_BITS:0]   prev_length,
   input  logic [31:0]          prev_count,
   input  logic [TIME_BITS-1:0] next_start,
   input  logic [TIME_BITS:0]   next_length,
   input  logic [31:0]          next_count,
   output logic [TIME_BITS-1:0] start,
   output logic [TIME_BITS:0]   length,
   output logic [31:0]          count,
   output logic                 lt_key,
   output logic                 le_key,
   output logic                 eq_key,
   output logic                 touch
);
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS:0]   length_ff, length_in;
   logic [31:0]          count_ff, count_in;
   logic [32:0]          sum;

   assign sum = {1'b0, count_ff} + {1'b0, next_count};

   always_comb begin
      start_in  = start_ff;
      length_in = length_ff;
      count_in  = count_ff;
      unique case (op)
         OP_INSERT: begin
            if (ins_here) begin
               start_in  = new_start;
               length_in = new_length;
               count_in  = new_count;
            end else if (take_prev) begin
               start_in  = prev_start;
               length_in = prev_length;
               count_in  = prev_count;
            end
         end
         OP_MERGE: begin
            if (merge_here) begin
               length_in = length_ff + next_length;
               count_in  = sum[32] ? COUNT_MAX : sum[31:0];
            end else if (take_next) begin
               start_in  = next_start;
               length_in = next_length;
               count_in  = next_count;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      length_ff <= length_in;
      count_ff  <= count_in;
   end

   assign start  = start_ff;
   assign length = length_ff;
   assign count  = count_ff;
   assign lt_key = start_ff < key;
   assign le_key = start_ff <= key;
   assign eq_key = start_ff == key;
   assign touch  = ({1'b0, start_ff} + length_ff) == {1'b0, next_start};
endmodule

// ===== bench/interval_table_coalescing_tb.sv =====
// Self-checking bench for interval_table_coalescing: directed and random add/query items.
// A scoreboard class mirrors the sorted interval table and checks every result item.
// Depends on itc_pkg and the interval_table_coalescing RTL.
module interval_table_coalescing_tb import itc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;
   localparam int WATCH_LIMIT = 4000;

   typedef struct {
      logic [1:0]  status;
      logic        covered;
      logic [31:0] start;
      logic [32:0] length;
      logic [31:0] count;
   } span_result_type;

   class interval_scoreboard_type;
      bit [31:0] starts[DEPTH];
      bit [32:0] lengths[DEPTH];
      bit [31:0] events[DEPTH];
      int used;
      span_result_type pending_q[$];
      int errors;

      function new();
         used = 0;
         errors = 0;
      endfunction

      function longint unsigned span_end(int idx);
         span_end = longint'(starts[idx]) + longint'(lengths[idx]);
      endfunction

      function void note_item(logic mode, logic [31:0] st, logic [31:0] len,
                              logic [31:0] cnt, logic [31:0] probe);
         span_result_type r;
         int pos;
         int lo;
         int hit;
         bit [32:0] csum;
         r = '{STATUS_DONE, 1'b0, 32'd0, 33'd0, 32'd0};
         if (mode == MODE_QUERY) begin
            hit = -1;
            for (int i = 0; i < used; i++) begin
               if (starts[i] <= probe) hit = i;
               else break;
            end
            if (hit >= 0 && longint'(probe - starts[hit]) < longint'(lengths[hit]))
               r = '{STATUS_DONE, 1'b1, starts[hit], lengths[hit], events[hit]};
         end else begin
            pos = 0;
            while (pos < used && starts[pos] < st) pos++;
            if (pos < used && starts[pos] == st) begin
               r = '{STATUS_DUP, 1'b0, starts[pos], lengths[pos], events[pos]};
            end else if (used >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               for (int i = used; i > pos; i--) begin
                  starts[i] = starts[i-1];
                  lengths[i] = lengths[i-1];
                  events[i] = events[i-1];
               end
               starts[pos] = st;
               lengths[pos] = {1'b0, len};
               events[pos] = cnt;
               used++;
               lo = pos;
               while (lo > 0 && span_end(lo-1) == longint'(starts[lo])) lo--;
               while (lo + 1 < used && span_end(lo) == longint'(starts[lo+1])) begin
                  lengths[lo] = lengths[lo] + lengths[lo+1];
                  csum = {1'b0, events[lo]} + {1'b0, events[lo+1]};
                  events[lo] = csum[32] ? COUNT_MAX : csum[31:0];
                  for (int k = lo + 1; k + 1 < used; k++) begin
                     starts[k] = starts[k+1];
                     lengths[k] = lengths[k+1];
                     events[k] = events[k+1];
                  end
                  used--;
               end
               r = '{STATUS_DONE, 1'b0, starts[lo], lengths[lo], events[lo]};
            end
         end
         pending_q.push_back(r);
      endfunction

      function void check_result(logic [1:0] status, logic covered, logic [31:0] st,
                                 logic [32:0] len, logic [31:0] cnt);
         span_result_type e;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Result item with nothing expected: status %0d", status);
            return;
         end
         e = pending_q.pop_front();
         if (status !== e.status || covered !== e.covered || st !== e.start ||
             len !== e.length || cnt !== e.count) begin
            errors++;
            if (errors <= 10)
               $display("Mismatch: expected %0d %0d %h %h %h, got %0d %0d %h %h %h",
                        e.status, e.covered, e.start, e.length, e.count,
                        status, covered, st, len, cnt);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = MODE_ADD;
   logic [31:0] req_start_time = '0;
   logic [31:0] req_span_length = '0;
   logic [31:0] req_event_count = '0;
   logic [31:0] req_probe_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_covered;
   logic [31:0] rsp_hit_start;
   logic [32:0] rsp_hit_length;
   logic [31:0] rsp_hit_count;

   interval_scoreboard_type table_sb = new();
   bit quiet = 0;
   bit hold_off = 0;
   int idle_cycles = 0;

   interval_table_coalescing i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic send_item(logic mode, logic [31:0] st, logic [31:0] len,
                            logic [31:0] cnt, logic [31:0] probe);
      int gap;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_start_time <= st;
      req_span_length <= len;
      req_event_count <= cnt;
      req_probe_time <= probe;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      table_sb.note_item(mode, st, len, cnt, probe);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_add(logic [31:0] st, logic [31:0] len, logic [31:0] cnt);
      send_item(MODE_ADD, st, len, cnt, $urandom);
   endtask

   task automatic send_query(logic [31:0] probe);
      send_item(MODE_QUERY, $urandom, $urandom, $urandom, probe);
   endtask

   task automatic send_random(bit allow_fill);
      int kind;
      int i;
      longint unsigned e;
      logic [31:0] len;
      kind = $urandom_range(0, 99);
      i = (table_sb.used > 0) ? $urandom_range(0, table_sb.used - 1) : 0;
      len = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60);
      if (kind < 30) begin
         if (table_sb.used > 0 && $urandom_range(0, 1) == 1) begin
            e = table_sb.span_end(i);
            send_query(table_sb.starts[i] + $urandom_range(0, 2) *
                       (table_sb.lengths[i] > 0 ? 32'(table_sb.lengths[i] - 1) : 32'd0) / 2
                       + ($urandom_range(0, 3) == 0 ? 32'd1 : 32'd0));
         end else begin
            send_query($urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000));
         end
      end else if (kind < 55 && allow_fill && table_sb.used >= 2) begin
         if (i + 1 >= table_sb.used) i = table_sb.used - 2;
         e = table_sb.span_end(i);
         if (e < longint'(table_sb.starts[i+1]))
            send_add(32'(e), 32'(longint'(table_sb.starts[i+1]) - e), $urandom);
         else
            send_add($urandom_range(0, 2000), len, $urandom);
      end else if (kind < 68 && table_sb.used > 0) begin
         e = table_sb.span_end(i);
         if (e <= 64'hFFFF_FFFF) send_add(32'(e), len, $urandom);
         else send_add($urandom, len, $urandom);
      end else if (kind < 78 && table_sb.used > 0) begin
         if (table_sb.starts[i] > 0) begin
            len = $urandom_range(1, table_sb.starts[i] > 100 ? 100 : table_sb.starts[i]);
            send_add(table_sb.starts[i] - len, len, $urandom);
         end else begin
            send_add(32'd0, len, $urandom);
         end
      end else if (kind < 86 && table_sb.used > 0) begin
         send_add(table_sb.starts[i], len, $urandom);
      end else begin
         send_add($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000),
                  len, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 9));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_query(32'd0);
      send_add(32'd100, 32'd50, 32'd5);
      send_query(32'd100);
      send_query(32'd149);
      send_query(32'd150);
      send_query(32'd99);
      send_add(32'd150, 32'd10, 32'hFFFF_FFFF);
      send_add(32'd100, 32'd7, 32'd7);
      send_add(32'd50, 32'd50, 32'd1);
      send_add(32'd300, 32'd0, 32'd3);
      send_query(32'd300);
      send_add(32'd200, 32'd100, 32'd4);
      send_query(32'd299);
      send_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_query(32'hFFFF_FFFF);
      send_add(32'hFFFF_FFFE, 32'd1, 32'd1);
      send_query(32'hFFFF_FFFF);
      send_add(32'd0, 32'hFFFF_FFFF, 32'd0);
      send_query(32'd0);
      send_query(32'h8000_0000);
      for (int n = 0; n < 1950; n++) begin
         if (n == 400) hold_off = 1;
         if (n == 1000) begin
            req_valid <= 1'b0;
            while (table_sb.pending_q.size() != 0) @(posedge clock);
         end
         if (n == 1750) quiet = 1;
         send_random(!(n >= 600 && n < 900));
      end
      req_valid <= 1'b0;
      while (table_sb.pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (table_sb.errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      int stall;
      int long_hold;
      stall = 0;
      long_hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            table_sb.check_result(rsp_status, rsp_covered, rsp_hit_start,
                                  rsp_hit_length, rsp_hit_count);
         if (hold_off) begin
            hold_off = 0;
            long_hold = 300;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCH_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule
